// ===== sv/sup_pkg.sv =====
// Shared types and constants for the sorted unique page list.
`default_nettype none

package sup_pkg;

  // Default sizing of the list
  localparam int SUP_CAPACITY  = 64;
  localparam int SUP_PAGE_BITS = 52;

  // Field widths on the stream ports
  localparam int PAGE_W      = 52;
  localparam int INDEX_W     = 6;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int OUT_COUNT_W = 7;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  // Item kinds; the unused code decodes as a read
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_CLEARED   = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_BEYOND    = 3'd5
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HEAD,
    S_READ,
    S_RESTORE
  } state_t;

endpackage

`default_nettype wire

// ===== sv/sorted_unique_page_list.sv =====
// Top level of the sorted unique page list: sequencer, count and result register.
//
// Keeps up to CAPACITY distinct page numbers in ascending order in one RAM with a
// registered read. Kind is taken from in_tuser, result status goes out on out_tuser.
// A clear, or a read whose index is not below the count, is answered from S_IDLE;
// a valid read reads the RAM first and is answered from S_READ. An insert walks the
// list from the top entry down through the single read port, copying each larger
// entry one place up as it goes, and stops at the first entry that is equal
// (duplicate) or smaller; if every entry is larger, S_HEAD puts the page at the
// bottom. A duplicate found below the top entry then walks back up in S_RESTORE to
// move the entries above it back down. A full list is walked the same way for the
// duplicate check but never written. Clear only zeroes the count; entries at or
// above the count are never visible. One item is in work at a time; a new
// transaction is taken once the result register is free or being emptied.
`default_nettype none

module sorted_unique_page_list
  import sup_pkg::*;
#(
  parameter int CAPACITY  = SUP_CAPACITY,
  parameter int PAGE_BITS = SUP_PAGE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: page [51:0], read_index [57:52], zero fill [63:58]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: kind [1:0]
  input  wire logic [KIND_W-1:0]      in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // out_tdata: entry_count [6:0], entry_value [58:7], zero fill [63:59]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: status [2:0]
  output logic [STATUS_W-1:0]         out_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Control and payload registers
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [PAGE_BITS-1:0]   page_r, page_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                status_r, status_nxt;
  logic [OUT_COUNT_W-1:0] ocount_r, ocount_nxt;
  logic [PAGE_W-1:0]      value_r, value_nxt;

  // RAM ports
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [PAGE_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [PAGE_BITS-1:0] rd_data;

  // Decoded input and helpers
  kind_t                        in_kind;
  logic [PAGE_BITS+PAGE_W-1:0]  page_wide;
  logic [PAGE_BITS-1:0]         in_page;
  logic [CNT_W+INDEX_W-1:0]     idx_wide;
  logic [CNT_W+INDEX_W-1:0]     cnt_wide;
  logic [CNT_W-1:0]             cnt_dec;
  logic [CNT_W-1:0]             cnt_inc;
  logic [AW-1:0]                pos_up;
  logic                         list_full;
  logic                         accept;

  // Result staging
  logic                         emit;
  status_t                      emit_status;
  logic [CNT_W-1:0]             emit_count;
  logic [PAGE_BITS-1:0]         emit_value;
  logic [CNT_W+OUT_COUNT_W-1:0] emit_count_wide;
  logic [PAGE_BITS+PAGE_W-1:0]  emit_value_wide;

  sup_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Unpack and size the input fields
  assign in_kind   = kind_t'(in_tuser);
  assign page_wide = {{PAGE_BITS{1'b0}}, in_tdata[PAGE_W-1:0]};
  assign in_page   = page_wide[PAGE_BITS-1:0];
  assign idx_wide  = {{CNT_W{1'b0}}, in_tdata[PAGE_W+INDEX_W-1:PAGE_W]};
  assign cnt_wide  = {{INDEX_W{1'b0}}, count_r};
  assign cnt_dec   = count_r - CNT_W'(1);
  assign cnt_inc   = count_r + CNT_W'(1);
  assign pos_up    = pos_r + AW'(1);
  assign list_full = (count_r == CNT_W'(CAPACITY));

  // Take a transaction only when idle and the result slot frees up
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Next state, RAM accesses and result staging
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    page_nxt      = page_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    ocount_nxt    = ocount_r;
    value_nxt     = value_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    emit          = 1'b0;
    emit_status   = ST_INSERTED;
    emit_count    = count_r;
    emit_value    = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_INSERT: begin
              page_nxt = in_page;
              if (count_r == '0) begin
                // Empty list: place the page at the bottom right away
                wr_en       = 1'b1;
                wr_data     = in_page;
                count_nxt   = cnt_inc;
                emit        = 1'b1;
                emit_status = ST_INSERTED;
                emit_count  = cnt_inc;
              end else begin
                // Start the walk at the top entry
                rd_en     = 1'b1;
                rd_addr   = cnt_dec[AW-1:0];
                pos_nxt   = cnt_dec[AW-1:0];
                state_nxt = S_SCAN;
              end
            end
            KIND_CLEAR: begin
              count_nxt   = '0;
              emit        = 1'b1;
              emit_status = ST_CLEARED;
              emit_count  = '0;
            end
            default: begin
              if (idx_wide < cnt_wide) begin
                rd_en     = 1'b1;
                rd_addr   = idx_wide[AW-1:0];
                state_nxt = S_READ;
              end else begin
                emit        = 1'b1;
                emit_status = ST_BEYOND;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_data == page_r) begin
          if (!list_full && (pos_r != cnt_dec[AW-1:0])) begin
            // Larger entries were already moved up: start moving them back down
            rd_en     = 1'b1;
            rd_addr   = pos_up + AW'(1);
            pos_nxt   = pos_up;
            state_nxt = S_RESTORE;
          end else begin
            emit        = 1'b1;
            emit_status = ST_DUPLICATE;
            state_nxt   = S_IDLE;
          end
        end else if (rd_data < page_r) begin
          // Insert point found just above this entry
          if (list_full) begin
            emit        = 1'b1;
            emit_status = ST_FULL;
          end else begin
            wr_en       = 1'b1;
            wr_addr     = pos_r + AW'(1);
            wr_data     = page_r;
            count_nxt   = cnt_inc;
            emit        = 1'b1;
            emit_status = ST_INSERTED;
            emit_count  = cnt_inc;
          end
          state_nxt = S_IDLE;
        end else begin
          // Larger entry: move it up one place unless the list is full, and keep walking down
          if (!list_full) begin
            wr_en   = 1'b1;
            wr_addr = pos_r + AW'(1);
            wr_data = rd_data;
          end
          if (pos_r == '0) begin
            if (list_full) begin
              emit        = 1'b1;
              emit_status = ST_FULL;
              state_nxt   = S_IDLE;
            end else begin
              state_nxt = S_HEAD;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_r - AW'(1);
            pos_nxt = pos_r - AW'(1);
          end
        end
      end

      S_RESTORE: begin
        // Pull the entry above back into this slot, walking up to the top entry
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = rd_data;
        if (pos_r == cnt_dec[AW-1:0]) begin
          emit        = 1'b1;
          emit_status = ST_DUPLICATE;
          state_nxt   = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_up + AW'(1);
          pos_nxt = pos_up;
        end
      end

      S_HEAD: begin
        // Smallest page so far: place it at the bottom
        wr_en       = 1'b1;
        wr_data     = page_r;
        count_nxt   = cnt_inc;
        emit        = 1'b1;
        emit_status = ST_INSERTED;
        emit_count  = cnt_inc;
        state_nxt   = S_IDLE;
      end

      S_READ: begin
        emit        = 1'b1;
        emit_status = ST_READ_OK;
        emit_value  = rd_data;
        state_nxt   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Load the result register
    if (emit) begin
      out_valid_nxt = 1'b1;
      status_nxt    = emit_status;
      ocount_nxt    = emit_count_wide[OUT_COUNT_W-1:0];
      value_nxt     = emit_value_wide[PAGE_W-1:0];
    end
  end

  assign emit_count_wide = {{OUT_COUNT_W{1'b0}}, emit_count};
  assign emit_value_wide = {{PAGE_W{1'b0}}, emit_value};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    page_r   <= page_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    ocount_r <= ocount_nxt;
    value_r  <= value_nxt;
  end

  // Pack the result transaction
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{(OUT_TDATA_W-PAGE_W-OUT_COUNT_W){1'b0}}, value_r, ocount_r};

endmodule

`default_nettype wire

// ===== sv/sup_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module sup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sorted_unique_page_list_tb.sv =====
// Self-checking testbench for the sorted unique page list: directed table plus random traffic.
`timescale 1ns / 1ps

module sorted_unique_page_list_tb
  import sup_pkg::*;
;

  localparam int                  RANDOM_ITEMS = 1100;
  localparam logic [PAGE_W-1:0]   PAGE_MAX     = {PAGE_W{1'b1}};
  localparam logic [KIND_W-1:0]   KIND_SPARE   = 2'd3;
  localparam logic [INDEX_W-1:0]  INDEX_MAX    = {INDEX_W{1'b1}};

  typedef struct packed {
    status_t                 status;
    logic [OUT_COUNT_W-1:0]  count;
    logic [PAGE_W-1:0]       value;
  } page_result_t;

  localparam page_result_t NO_RESULT = '{ST_INSERTED, '0, '0};

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [PAGE_W-1:0]   page;
    logic [INDEX_W-1:0]  idx;
    bit                  typed;
    page_result_t        res;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]      in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  // Shadow copy of the list
  logic [PAGE_W-1:0]  list_pages [SUP_CAPACITY];
  int                 list_len;

  page_result_t  pending_results [$];
  int            mismatch_count;
  int            items_sent;
  int            burst_left;
  logic [15:0]   stall_pattern;
  int            stall_phase;

  dir_row_t dir_rows [25] = '{
    '{KIND_READ,   '0,                 6'd0,      1'b1, '{ST_BEYOND,    7'd0, '0}},
    '{KIND_READ,   '0,                 INDEX_MAX, 1'b1, '{ST_BEYOND,    7'd0, '0}},
    '{KIND_INSERT, PAGE_MAX,           6'd0,      1'b1, '{ST_INSERTED,  7'd1, '0}},
    '{KIND_INSERT, '0,                 6'd0,      1'b1, '{ST_INSERTED,  7'd2, '0}},
    '{KIND_INSERT, PAGE_MAX,           6'd0,      1'b1, '{ST_DUPLICATE, 7'd2, '0}},
    '{KIND_INSERT, '0,                 6'd0,      1'b1, '{ST_DUPLICATE, 7'd2, '0}},
    '{KIND_READ,   '0,                 6'd0,      1'b1, '{ST_READ_OK,   7'd2, '0}},
    '{KIND_READ,   '0,                 6'd1,      1'b1, '{ST_READ_OK,   7'd2, PAGE_MAX}},
    '{KIND_READ,   '0,                 6'd2,      1'b1, '{ST_BEYOND,    7'd2, '0}},
    '{KIND_SPARE,  '0,                 6'd1,      1'b1, '{ST_READ_OK,   7'd2, PAGE_MAX}},
    '{KIND_INSERT, 52'h5555555555555,  6'd0,      1'b0, NO_RESULT},
    '{KIND_INSERT, 52'hAAAAAAAAAAAAA,  6'd0,      1'b0, NO_RESULT},
    '{KIND_INSERT, 52'd1,              6'd0,      1'b0, NO_RESULT},
    '{KIND_INSERT, PAGE_MAX - 52'd1,   6'd0,      1'b0, NO_RESULT},
    '{KIND_READ,   '0,                 INDEX_MAX, 1'b1, '{ST_BEYOND,    7'd6, '0}},
    '{KIND_READ,   PAGE_MAX,           6'd1,      1'b0, NO_RESULT},
    '{KIND_READ,   '0,                 6'd2,      1'b0, NO_RESULT},
    '{KIND_READ,   '0,                 6'd4,      1'b0, NO_RESULT},
    '{KIND_SPARE,  '0,                 6'd5,      1'b0, NO_RESULT},
    '{KIND_INSERT, 52'h123456789ABCD,  6'd42,     1'b0, NO_RESULT},
    '{KIND_CLEAR,  PAGE_MAX,           INDEX_MAX, 1'b1, '{ST_CLEARED,   7'd0, '0}},
    '{KIND_READ,   '0,                 6'd0,      1'b1, '{ST_BEYOND,    7'd0, '0}},
    '{KIND_SPARE,  '0,                 6'd0,      1'b1, '{ST_BEYOND,    7'd0, '0}},
    '{KIND_INSERT, '0,                 6'd0,      1'b1, '{ST_INSERTED,  7'd1, '0}},
    '{KIND_CLEAR,  '0,                 6'd0,      1'b1, '{ST_CLEARED,   7'd0, '0}}
  };

  sorted_unique_page_list u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one item to the shadow list and return the result it should produce
  function automatic page_result_t update_page_list(input logic [KIND_W-1:0] kind,
                                                    input logic [PAGE_W-1:0] page,
                                                    input logic [INDEX_W-1:0] idx);
    page_result_t res;
    int           pos;
    bit           found;
    res = '{ST_INSERTED, '0, '0};
    found = 1'b0;
    if (kind == KIND_INSERT) begin
      for (int i = 0; i < list_len; i++)
        if (list_pages[i] == page) found = 1'b1;
      if (found) begin
        res.status = ST_DUPLICATE;
      end else if (list_len >= SUP_CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // Find the sorted slot, shift larger entries up, then drop the page in
        pos = list_len;
        for (int i = list_len - 1; i >= 0; i--)
          if (page < list_pages[i]) pos = i;
        for (int i = list_len; i > pos; i--)
          list_pages[i] = list_pages[i-1];
        list_pages[pos] = page;
        list_len++;
      end
    end else if (kind == KIND_CLEAR) begin
      for (int i = 0; i < SUP_CAPACITY; i++) list_pages[i] = '0;
      list_len = 0;
      res.status = ST_CLEARED;
    end else begin
      // Both read and the spare kind code land here
      if (int'(idx) < list_len) begin
        res.status = ST_READ_OK;
        res.value  = list_pages[idx];
      end else begin
        res.status = ST_BEYOND;
      end
    end
    res.count = OUT_COUNT_W'(list_len);
    return res;
  endfunction

  // Drive one transaction, hold until accepted, then idle between bursts
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [PAGE_W-1:0] page,
                           input logic [INDEX_W-1:0] idx, input bit typed,
                           input page_result_t typed_res);
    page_result_t predicted;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDATA_W-PAGE_W-INDEX_W){1'b0}}, idx, page};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = update_page_list(kind, page, idx);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  function automatic logic [PAGE_W-1:0] wide_page();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[PAGE_W-1:0];
  endfunction

  // Mix of wide, low, near-top and already stored pages
  function automatic logic [PAGE_W-1:0] pick_page();
    case ($urandom_range(0, 3))
      0: return wide_page();
      1: return PAGE_W'($urandom_range(0, 200));
      2: return PAGE_MAX - PAGE_W'($urandom_range(0, 200));
      default: begin
        if (list_len > 0) return list_pages[$urandom_range(0, list_len - 1)];
        return wide_page();
      end
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if (list_len > 0 && $urandom_range(0, 9) < 6) return INDEX_W'($urandom_range(0, list_len - 1));
    return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
  endfunction

  function automatic logic [KIND_W-1:0] pick_read_kind();
    return ($urandom_range(0, 3) == 0) ? KIND_SPARE : KIND_READ;
  endfunction

  // Stimulus
  initial begin
    int roll;
    mismatch_count = 0;
    items_sent     = 0;
    burst_left     = $urandom_range(1, 12);
    list_len       = 0;
    for (int i = 0; i < SUP_CAPACITY; i++) list_pages[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].page, dir_rows[i].idx, dir_rows[i].typed,
                dir_rows[i].res);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 3) begin
        // Fill to capacity, then hit the full list with duplicates, new pages and reads
        send_item(KIND_CLEAR, wide_page(), INDEX_W'($urandom), 1'b0, NO_RESULT);
        while (list_len < SUP_CAPACITY) begin
          if ($urandom_range(0, 4) == 0)
            send_item(pick_read_kind(), wide_page(), pick_index(), 1'b0, NO_RESULT);
          else
            send_item(KIND_INSERT, wide_page(), INDEX_W'($urandom), 1'b0, NO_RESULT);
        end
        repeat (12) begin
          roll = $urandom_range(0, 2);
          if (roll == 0)
            send_item(KIND_INSERT, list_pages[$urandom_range(0, list_len - 1)],
                      INDEX_W'($urandom), 1'b0, NO_RESULT);
          else if (roll == 1)
            send_item(KIND_INSERT, pick_page(), INDEX_W'($urandom), 1'b0, NO_RESULT);
          else
            send_item(pick_read_kind(), wide_page(), INDEX_W'($urandom), 1'b0, NO_RESULT);
        end
      end else begin
        // Mixed traffic on a partly filled list
        repeat ($urandom_range(20, 60)) begin
          roll = $urandom_range(0, 19);
          if (roll < 11)
            send_item(KIND_INSERT, pick_page(), INDEX_W'($urandom), 1'b0, NO_RESULT);
          else if (roll < 19)
            send_item(pick_read_kind(), wide_page(), pick_index(), 1'b0, NO_RESULT);
          else
            send_item(KIND_CLEAR, wide_page(), INDEX_W'($urandom), 1'b0, NO_RESULT);
        end
      end
    end
    in_tvalid <= 1'b0;

    // Drain outstanding results, then allow a full list walk for stray outputs
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Receiver stalls: rotate through a random ready pattern, sometimes all ready
  initial begin
    stall_pattern = 16'hFFFF;
    stall_phase   = 0;
  end

  always @(posedge clk) begin
    out_tready <= stall_pattern[stall_phase];
    if (stall_phase == 15) begin
      stall_phase   <= 0;
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      stall_phase <= stall_phase + 1;
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    page_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending item: status %0d", out_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[OUT_COUNT_W-1:0] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_tdata[OUT_COUNT_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[OUT_COUNT_W +: PAGE_W] !== want.value) begin
          $error("entry_value: expected %0h, got %0h", want.value,
                 out_tdata[OUT_COUNT_W +: PAGE_W]);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sorted_unique_page_list.f =====
sv/sup_pkg.sv
sv/sup_ram.sv
sv/sorted_unique_page_list.sv
tb/sorted_unique_page_list_tb.sv
